>>> src/tvhi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhi_pkg
// Shared types and constants for the timed vector history interpolator.
// ----------------------------------------------------------------------------
package tvhi_pkg;

    localparam int CAPACITY = 16;
    localparam int DIM      = 3;
    localparam int NCELL    = CAPACITY + 1;
    localparam int CNT_W    = $clog2(NCELL + 1);
    localparam int IDX_W    = $clog2(NCELL);
    localparam int FRAC_W   = 17;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_EXACT  = 3'd1;
    localparam logic [2:0] ST_BEFORE = 3'd2;
    localparam logic [2:0] ST_AFTER  = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    localparam logic REG_MAX_POINTS   = 1'b0;
    localparam logic REG_TIME_EPSILON = 1'b1;

    typedef logic [DIM-1:0][31:0] vec_t;

    typedef struct packed {
        logic signed [31:0] time_val;
        vec_t               vec;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SELECT,
        S_DECIDE,
        S_EVICT,
        S_DIVIDE,
        S_BLEND,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               evicted;
        logic               prev_valid;
        logic signed [31:0] prev_time;
        logic               next_valid;
        logic signed [31:0] next_time;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } result_t;

endpackage

>>> src/timed_vector_history_interp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_vector_history_interp_top
// Time-sorted sample table with exact-hit lookup and linear interpolation.
// ----------------------------------------------------------------------------
// One transaction at a time. A clear or an unused operation goes from
// acceptance straight to the result; a store passes through search, select,
// decide and evict; a query through search, select and decide, and an
// interpolating query then through the bit-serial fraction divider and the
// blend, one multiply per cycle over three components. The table is a row
// of sample cells that shift as a chain on insert and on eviction. A new
// transaction is taken while the previous result still waits on the output.
module timed_vector_history_interp_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tvhi_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tvhi_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NC = tvhi_pkg::NCELL;
    localparam int CW = tvhi_pkg::CNT_W;
    localparam int IW = tvhi_pkg::IDX_W;
    localparam int FW = tvhi_pkg::FRAC_W;

    tvhi_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic [4:0]       max_points_reg;
    logic [15:0]      eps_reg;
    logic             out_valid_reg;
    logic             finish;

    logic [1:0]         op_reg;
    logic signed [31:0] t_reg;
    tvhi_pkg::vec_t     v_reg;
    logic [CW-1:0]      le_reg;
    tvhi_pkg::entry_t   pe_reg, ne_reg;
    logic               hp_reg, hn_reg;
    tvhi_pkg::result_t  res_reg, out_reg;

    logic [31:0]    den_reg, rem_reg;
    logic [FW-1:0]  nlow_reg, q_reg;
    logic [4:0]     div_cnt_reg;
    logic [1:0]     dim_reg, phase_reg;
    logic signed [49:0] prod_a_reg, prod_b_reg;

    tvhi_pkg::entry_t   cell_data [NC];
    logic [NC-1:0]      cell_le;
    tvhi_pkg::cell_op_t cell_op [NC];
    tvhi_pkg::entry_t   new_entry;

    assign new_entry.time_val = t_reg;
    assign new_entry.vec      = v_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        tvhi_pkg::entry_t pd, nd;
        if (i == 0)
        begin : g_first
            assign pd = '0;
        end
        else
        begin : g_mid
            assign pd = cell_data[i-1];
        end
        if (i == NC - 1)
        begin : g_last
            assign nd = '0;
        end
        else
        begin : g_nlast
            assign nd = cell_data[i+1];
        end
        tvhi_cell u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .load_data  (new_entry),
            .prev_data  (pd),
            .next_data  (nd),
            .probe_time (t_reg),
            .data       (cell_data[i]),
            .le         (cell_le[i])
        );
    end

    // count of stored samples at or before the probe time
    logic [CW-1:0] le_cnt;
    always_comb
    begin
        le_cnt = '0;
        for (int i = 0; i < NC; i++)
        begin
            if (cell_le[i] && (CW'(i) < count_reg))
            begin
                le_cnt = le_cnt + CW'(1);
            end
        end
    end

    logic [32:0] dprev, dnext;
    logic        match_prev, match_next;
    logic [CW-1:0] limit;

    assign dprev = {t_reg[31], t_reg} - {pe_reg.time_val[31], pe_reg.time_val};
    assign dnext = {ne_reg.time_val[31], ne_reg.time_val} - {t_reg[31], t_reg};
    assign match_prev = hp_reg && (dprev <= 33'(eps_reg));
    assign match_next = hn_reg && (dnext <= 33'(eps_reg));
    assign limit = ((max_points_reg == 5'd0) || (max_points_reg > 5'(tvhi_pkg::CAPACITY)))
                   ? CW'(tvhi_pkg::CAPACITY) : CW'(max_points_reg);

    logic        over;
    assign over = (count_reg > limit);

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            cell_op[i] = tvhi_pkg::CELL_HOLD;
            if (state_reg == tvhi_pkg::S_DECIDE && op_reg == tvhi_pkg::OP_STORE)
            begin
                if (match_prev)
                begin
                    if (CW'(i) == le_reg - CW'(1))
                        cell_op[i] = tvhi_pkg::CELL_LOAD;
                end
                else if (match_next)
                begin
                    if (CW'(i) == le_reg)
                        cell_op[i] = tvhi_pkg::CELL_LOAD;
                end
                else if (CW'(i) == le_reg)
                begin
                    cell_op[i] = tvhi_pkg::CELL_LOAD;
                end
                else if (CW'(i) > le_reg && CW'(i) <= count_reg)
                begin
                    cell_op[i] = tvhi_pkg::CELL_TAKE_PREV;
                end
            end
            else if (state_reg == tvhi_pkg::S_EVICT && over)
            begin
                if (CW'(i + 1) < count_reg)
                    cell_op[i] = tvhi_pkg::CELL_TAKE_NEXT;
            end
        end
    end

    // divider and blend datapath
    logic [31:0]    num, den;
    logic [48:0]    dividend;
    logic [32:0]    trial;
    logic           qbit;
    logic [FW-1:0]  gfrac;
    logic signed [50:0] blend_sum;

    assign num      = t_reg - pe_reg.time_val;
    assign den      = ne_reg.time_val - pe_reg.time_val;
    assign dividend = {1'b0, num, 16'b0} + 49'(den >> 1);
    assign trial    = {rem_reg, nlow_reg[FW-1]};
    assign qbit     = (trial >= {1'b0, den_reg});
    assign gfrac    = FW'(65536) - q_reg;
    assign blend_sum = 51'(prod_a_reg) + 51'(prod_b_reg) + 51'(32768);

    assign finish = (state_reg == tvhi_pkg::S_FINISH) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tvhi_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.operation == tvhi_pkg::OP_STORE ||
                        item.operation == tvhi_pkg::OP_QUERY)
                        state_next = tvhi_pkg::S_SEARCH;
                    else
                        state_next = tvhi_pkg::S_FINISH;
                end
            end
            tvhi_pkg::S_SEARCH: state_next = tvhi_pkg::S_SELECT;
            tvhi_pkg::S_SELECT: state_next = tvhi_pkg::S_DECIDE;
            tvhi_pkg::S_DECIDE:
            begin
                if (op_reg == tvhi_pkg::OP_STORE)
                    state_next = tvhi_pkg::S_EVICT;
                else if (!match_prev && !match_next && hp_reg && hn_reg)
                    state_next = tvhi_pkg::S_DIVIDE;
                else
                    state_next = tvhi_pkg::S_FINISH;
            end
            tvhi_pkg::S_EVICT: state_next = tvhi_pkg::S_FINISH;
            tvhi_pkg::S_DIVIDE:
            begin
                if (div_cnt_reg == 5'(FW - 1))
                    state_next = tvhi_pkg::S_BLEND;
            end
            tvhi_pkg::S_BLEND:
            begin
                if (phase_reg == 2'd2 && dim_reg == 2'(tvhi_pkg::DIM - 1))
                    state_next = tvhi_pkg::S_FINISH;
            end
            tvhi_pkg::S_FINISH:
            begin
                if (finish)
                    state_next = tvhi_pkg::S_IDLE;
            end
            default: state_next = tvhi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tvhi_pkg::S_IDLE;
            count_reg      <= '0;
            max_points_reg <= '0;
            eps_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == tvhi_pkg::REG_MAX_POINTS)
                    max_points_reg <= pwdata[4:0];
                else
                    eps_reg <= pwdata[15:0];
            end
            if (state_reg == tvhi_pkg::S_IDLE && item_valid &&
                item.operation == tvhi_pkg::OP_CLEAR)
                count_reg <= '0;
            else if (state_reg == tvhi_pkg::S_DECIDE && op_reg == tvhi_pkg::OP_STORE &&
                     !match_prev && !match_next)
                count_reg <= count_reg + CW'(1);
            else if (state_reg == tvhi_pkg::S_EVICT && over)
                count_reg <= count_reg - CW'(1);
            if (finish)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tvhi_pkg::S_IDLE:
            begin
                op_reg  <= item.operation;
                t_reg   <= item.sample_time;
                v_reg   <= {item.value_z, item.value_y, item.value_x};
                res_reg <= '0;
            end
            tvhi_pkg::S_SEARCH: le_reg <= le_cnt;
            tvhi_pkg::S_SELECT:
            begin
                pe_reg <= cell_data[IW'(le_reg - CW'(1))];
                ne_reg <= cell_data[IW'(le_reg)];
                hp_reg <= (le_reg != '0);
                hn_reg <= (le_reg < count_reg);
            end
            tvhi_pkg::S_DECIDE:
            begin
                rem_reg     <= dividend[48:17];
                nlow_reg    <= dividend[16:0];
                den_reg     <= den;
                div_cnt_reg <= '0;
                dim_reg     <= '0;
                phase_reg   <= '0;
                if (op_reg == tvhi_pkg::OP_QUERY)
                begin
                    if (match_prev || match_next)
                    begin
                        res_reg.status     <= tvhi_pkg::ST_EXACT;
                        res_reg.prev_valid <= 1'b1;
                        res_reg.prev_time  <= match_prev ? pe_reg.time_val : ne_reg.time_val;
                        res_reg.out_x <= match_prev ? pe_reg.vec[0] : ne_reg.vec[0];
                        res_reg.out_y <= match_prev ? pe_reg.vec[1] : ne_reg.vec[1];
                        res_reg.out_z <= match_prev ? pe_reg.vec[2] : ne_reg.vec[2];
                    end
                    else
                    begin
                        res_reg.prev_valid <= hp_reg;
                        res_reg.prev_time  <= hp_reg ? pe_reg.time_val : '0;
                        res_reg.next_valid <= hn_reg;
                        res_reg.next_time  <= hn_reg ? ne_reg.time_val : '0;
                        if (hp_reg && hn_reg)
                            res_reg.status <= tvhi_pkg::ST_INTERP;
                        else if (hn_reg)
                            res_reg.status <= tvhi_pkg::ST_BEFORE;
                        else if (hp_reg)
                            res_reg.status <= tvhi_pkg::ST_AFTER;
                        else
                            res_reg.status <= tvhi_pkg::ST_EMPTY;
                    end
                end
            end
            tvhi_pkg::S_EVICT: res_reg.evicted <= over;
            tvhi_pkg::S_DIVIDE:
            begin
                rem_reg     <= qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                nlow_reg    <= {nlow_reg[FW-2:0], 1'b0};
                q_reg       <= {q_reg[FW-2:0], qbit};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            tvhi_pkg::S_BLEND:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        prod_a_reg <= $signed(ne_reg.vec[dim_reg]) * $signed({1'b0, q_reg});
                        phase_reg  <= 2'd1;
                    end
                    2'd1:
                    begin
                        prod_b_reg <= $signed(pe_reg.vec[dim_reg]) * $signed({1'b0, gfrac});
                        phase_reg  <= 2'd2;
                    end
                    default:
                    begin
                        case (dim_reg)
                            2'd0:    res_reg.out_x <= blend_sum[47:16];
                            2'd1:    res_reg.out_y <= blend_sum[47:16];
                            default: res_reg.out_z <= blend_sum[47:16];
                        endcase
                        dim_reg   <= dim_reg + 2'd1;
                        phase_reg <= 2'd0;
                    end
                endcase
            end
            default:
            begin
                if (finish)
                    out_reg <= res_reg;
            end
        endcase
    end

    assign item_ready   = (state_reg == tvhi_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == tvhi_pkg::REG_TIME_EPSILON) ? {16'b0, eps_reg}
                                                                   : {27'b0, max_points_reg};

endmodule

>>> src/tvhi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhi_cell
// One table slot: holds a sample, shifts with its neighbors, compares time.
// ----------------------------------------------------------------------------
module tvhi_cell (
    input  logic                clk,
    input  tvhi_pkg::cell_op_t  op,
    input  tvhi_pkg::entry_t    load_data,
    input  tvhi_pkg::entry_t    prev_data,
    input  tvhi_pkg::entry_t    next_data,
    input  logic signed [31:0]  probe_time,
    output tvhi_pkg::entry_t    data,
    output logic                le
);

    tvhi_pkg::entry_t data_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            tvhi_pkg::CELL_LOAD:      data_reg <= load_data;
            tvhi_pkg::CELL_TAKE_PREV: data_reg <= prev_data;
            tvhi_pkg::CELL_TAKE_NEXT: data_reg <= next_data;
            default:                  data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;
    assign le   = (data_reg.time_val <= probe_time);

endmodule

>>> src/tvhi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhi_checker
// Port-level checks for the timed vector history interpolator.
// ----------------------------------------------------------------------------
module tvhi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input tvhi_pkg::result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_interp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == tvhi_pkg::ST_INTERP && !result.evicted &&
        (result.prev_valid || result.next_valid) |-> result.prev_valid && result.next_valid)
        else $error("interpolated result lacks a neighbor");

    a_before: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == tvhi_pkg::ST_BEFORE |->
        !result.prev_valid && result.next_valid && result.out_x == '0)
        else $error("before-first result malformed");

    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.evicted |->
        result.status == tvhi_pkg::ST_INTERP && !result.prev_valid && !result.next_valid)
        else $error("store result carries query fields");

endmodule

bind timed_vector_history_interp_top tvhi_checker u_tvhi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
